// ----- sv/mrct_pkg.sv -----
// ----------------------------------------------------------------------------
// mrct_pkg
// Shared constants, codes and types of the mixed-radix contingency table.
// ----------------------------------------------------------------------------
`default_nettype none

package mrct_pkg;

   // default parameter values
   localparam int DEF_TABLE_DEPTH = 4096;
   localparam int DEF_MAX_COLUMNS = 4;
   localparam int DEF_COUNT_BITS  = 32;

   // fixed field widths
   localparam int CODE_COLUMNS   = 4;
   localparam int CODE_BITS      = 9;
   localparam int LEVEL_BITS     = 9;
   localparam int NCOL_BITS      = 3;
   localparam int OUT_INDEX_BITS = 12;
   localparam int OUT_COUNT_BITS = 32;
   localparam int REQ_DATA_BITS  = 48;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 48;
   localparam int RSP_USER_BITS  = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;
   localparam int QUEUE_DEPTH    = 2;

   // request modes
   localparam logic [1:0] MODE_COUNT      = 2'd0;
   localparam logic [1:0] MODE_READ       = 2'd1;
   localparam logic [1:0] MODE_READ_CLEAR = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_CODE  = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMNS_USED  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVELS_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVELS_SECOND = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVELS_THIRD  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVELS_FOURTH = 3'd4;

   // operation carried out by the back end
   typedef enum logic [1:0] {
      OP_COUNT,
      OP_READ,
      OP_CLEAR,
      OP_REPORT
   } op_type;

   // command passed from front end to back end
   typedef struct packed {
      op_type                    op;
      logic [1:0]                status;
      logic [OUT_INDEX_BITS-1:0] rsp_index;
   } cmd_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CALC,
      FE_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BE_CLEAR,
      BE_IDLE,
      BE_EXEC
   } back_state_type;

endpackage

`default_nettype wire

// ----- sv/mixed_radix_contingency_table.sv -----
// Count request: FE_CALC forms the bin index, one radix digit a cycle over the N
// columns in use; FE_PUSH queues it; the back end pops it in BE_IDLE, updates the
// bin in BE_EXEC and registers the response. Read and read-and-clear requests are
// queued in the cycle they are accepted. The back end takes a new command only after
// the last one's read-modify-write on the bin store, with its registered read port.
// Reset: synchronous; then a clearing pass over all TABLE_DEPTH bins with req_tready low.
// ----------------------------------------------------------------------------
// mixed_radix_contingency_table
// Multi-way contingency table: mixed-radix bin index, saturating counters,
// read and read-and-clear of single bins.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_contingency_table #(
   parameter int TABLE_DEPTH = mrct_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_COLUMNS = mrct_pkg::DEF_MAX_COLUMNS,
   parameter int COUNT_BITS  = mrct_pkg::DEF_COUNT_BITS
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request: code_first[8:0] code_second[17:9] code_third[26:18]
   //          code_fourth[35:27] read_index[47:36]
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [mrct_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // request: mode[1:0]
   input  wire  [mrct_pkg::REQ_USER_BITS-1:0]  req_tuser,
   // response: bin_index[11:0] bin_count[43:12] zero[47:44]
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mrct_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // response: status[1:0]
   output logic [mrct_pkg::RSP_USER_BITS-1:0]  rsp_tuser,
   // configuration writes
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [mrct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [mrct_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import mrct_pkg::*;

   localparam int ADDR_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int QUEUE_BITS = $bits(cmd_type) + ADDR_BITS;

   logic                  clear_busy;
   logic                  queue_full;
   logic                  push;
   cmd_type               push_cmd;
   logic [ADDR_BITS-1:0]  push_addr;
   logic                  pop;
   logic                  head_valid;
   logic [QUEUE_BITS-1:0] head_data;
   cmd_type               head_cmd;
   logic [ADDR_BITS-1:0]  head_addr;

   assign {head_cmd, head_addr} = head_data;

   // request intake and index build
   mrct_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_COLUMNS (MAX_COLUMNS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .clear_busy (clear_busy),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_addr  (push_addr)
   );

   // command queue
   mrct_queue #(
      .WIDTH (QUEUE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_cmd, push_addr}),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // bin store and response
   mrct_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_addr  (head_addr),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- sv/mrct_front.sv -----
// ----------------------------------------------------------------------------
// mrct_front
// Accepts requests, holds the configuration and forms the bin index one
// column per cycle, then queues a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrct_front #(
   parameter int TABLE_DEPTH = mrct_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_COLUMNS = mrct_pkg::DEF_MAX_COLUMNS,
   parameter int ADDR_BITS   = $clog2(mrct_pkg::DEF_TABLE_DEPTH)
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [mrct_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire  [mrct_pkg::REQ_USER_BITS-1:0]  req_tuser,
   // configuration channel
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [mrct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [mrct_pkg::CSR_DATA_BITS-1:0]  csr_data,
   // back end status and queue
   input  wire                                 clear_busy,
   input  wire                                 queue_full,
   output logic                                push,
   output mrct_pkg::cmd_type                   push_cmd,
   output logic [ADDR_BITS-1:0]                push_addr
);
   import mrct_pkg::*;

   localparam int COL_LIMIT = (MAX_COLUMNS < CODE_COLUMNS) ? MAX_COLUMNS : CODE_COLUMNS;
   localparam int SIZE_BITS = $clog2(TABLE_DEPTH + 2);
   localparam int PROD_BITS = SIZE_BITS + LEVEL_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam logic [SIZE_BITS-1:0] SIZE_CLAMP = SIZE_BITS'(TABLE_DEPTH + 1);
   localparam logic [SIZE_BITS-1:0] SIZE_DEPTH = SIZE_BITS'(TABLE_DEPTH);
   localparam logic [PROD_BITS-1:0] PROD_DEPTH = PROD_BITS'(TABLE_DEPTH);
   localparam logic [SUM_BITS-1:0]  SUM_DEPTH  = SUM_BITS'(TABLE_DEPTH);

   // request fields
   logic [OUT_INDEX_BITS-1:0] read_index;
   assign read_index = req_tdata[47:36];

   // configuration registers
   logic [NCOL_BITS-1:0]  cols_used_ff;
   logic [LEVEL_BITS-1:0] levels_ff [CODE_COLUMNS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_used_ff <= NCOL_BITS'(1);
         levels_ff[0] <= LEVEL_BITS'(2);
         levels_ff[1] <= LEVEL_BITS'(1);
         levels_ff[2] <= LEVEL_BITS'(1);
         levels_ff[3] <= LEVEL_BITS'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COLUMNS_USED:  cols_used_ff <= csr_data[NCOL_BITS-1:0];
            CSR_LEVELS_FIRST:  levels_ff[0] <= csr_data;
            CSR_LEVELS_SECOND: levels_ff[1] <= csr_data;
            CSR_LEVELS_THIRD:  levels_ff[2] <= csr_data;
            CSR_LEVELS_FOURTH: levels_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // number of columns in use, clamped to the supported range
   logic [NCOL_BITS-1:0] ncol_clamped;
   always_comb begin
      if (cols_used_ff == '0) begin
         ncol_clamped = NCOL_BITS'(1);
      end else if (cols_used_ff > NCOL_BITS'(COL_LIMIT)) begin
         ncol_clamped = NCOL_BITS'(COL_LIMIT);
      end else begin
         ncol_clamped = cols_used_ff;
      end
   end

   // index build registers
   front_state_type       state_ff, state_in;
   logic [1:0]            col_ff, col_in;
   logic [NCOL_BITS-1:0]  ncol_ff, ncol_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic [ADDR_BITS-1:0]  idx_ff, idx_in;
   logic                  bad_ff, bad_in;
   logic                  over_ff, over_in;
   logic [CODE_BITS-1:0]  codes_ff [CODE_COLUMNS];
   logic                  load_codes;

   // one radix digit per cycle
   logic [CODE_BITS-1:0]  code_sel;
   logic [LEVEL_BITS-1:0] lv_sel;
   logic                  code_ok;
   logic [CODE_BITS-1:0]  digit;
   logic [PROD_BITS-1:0]  term;
   logic [PROD_BITS-1:0]  prod;
   logic [SUM_BITS-1:0]   sum;

   assign code_sel = codes_ff[col_ff];
   assign lv_sel   = levels_ff[col_ff];
   assign code_ok  = (code_sel != '0) && (code_sel <= lv_sel);
   assign digit    = code_sel - CODE_BITS'(1);
   assign term     = PROD_BITS'(digit) * PROD_BITS'(size_ff);
   assign prod     = PROD_BITS'(size_ff) * PROD_BITS'(lv_sel);
   assign sum      = SUM_BITS'(idx_ff) + SUM_BITS'(term);

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      ncol_in    = ncol_ff;
      size_in    = size_ff;
      idx_in     = idx_ff;
      bad_in     = bad_ff;
      over_in    = over_ff;
      load_codes = 1'b0;
      req_tready = 1'b0;
      push       = 1'b0;
      push_cmd   = '{op: OP_REPORT, status: ST_OK, rsp_index: '0};
      push_addr  = '0;

      case (state_ff)
         FE_IDLE: begin
            req_tready = !clear_busy && !queue_full;
            if (req_tvalid && req_tready) begin
               case (req_tuser)
                  MODE_COUNT: begin
                     load_codes = 1'b1;
                     col_in     = '0;
                     ncol_in    = ncol_clamped;
                     size_in    = SIZE_BITS'(1);
                     idx_in     = '0;
                     bad_in     = 1'b0;
                     over_in    = 1'b0;
                     state_in   = FE_CALC;
                  end
                  default: begin
                     push = 1'b1;
                     push_cmd.rsp_index = read_index;
                     if (int'(read_index) >= TABLE_DEPTH) begin
                        push_cmd.op     = OP_REPORT;
                        push_cmd.status = ST_BAD_INDEX;
                     end else begin
                        push_cmd.op = (req_tuser == MODE_READ_CLEAR) ? OP_CLEAR : OP_READ;
                        push_addr   = ADDR_BITS'(read_index);
                     end
                  end
               endcase
            end
         end

         FE_CALC: begin
            // size saturates just above the depth; a zero level still zeroes it
            size_in = (prod > PROD_DEPTH) ? SIZE_CLAMP : prod[SIZE_BITS-1:0];
            if (!code_ok) begin
               bad_in = 1'b1;
            end else if (sum >= SUM_DEPTH) begin
               over_in = 1'b1;
            end else begin
               idx_in = sum[ADDR_BITS-1:0];
            end
            if ({1'b0, col_ff} == ncol_ff - NCOL_BITS'(1)) begin
               state_in = FE_PUSH;
            end else begin
               col_in = col_ff + 2'd1;
            end
         end

         FE_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = FE_IDLE;
               if (size_ff > SIZE_DEPTH) begin
                  push_cmd.status = ST_TOO_LARGE;
               end else if (bad_ff || over_ff) begin
                  push_cmd.status = ST_BAD_CODE;
               end else begin
                  push_cmd.op        = OP_COUNT;
                  push_cmd.rsp_index = OUT_INDEX_BITS'(idx_ff);
                  push_addr          = idx_ff;
               end
            end
         end

         default: state_in = FE_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      ncol_ff <= ncol_in;
      size_ff <= size_in;
      idx_ff  <= idx_in;
      bad_ff  <= bad_in;
      over_ff <= over_in;
      if (load_codes) begin
         codes_ff[0] <= req_tdata[8:0];
         codes_ff[1] <= req_tdata[17:9];
         codes_ff[2] <= req_tdata[26:18];
         codes_ff[3] <= req_tdata[35:27];
      end
   end

endmodule

`default_nettype wire

// ----- sv/mrct_queue.sv -----
// ----------------------------------------------------------------------------
// mrct_queue
// Short first-word-fall-through queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrct_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mrct_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   output logic             full,
   input  wire              pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import mrct_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNT_BITS'(1);
            2'b01:   count_ff <= count_ff - CNT_BITS'(1);
            default: ;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/mrct_back.sv -----
// ----------------------------------------------------------------------------
// mrct_back
// Holds the bin store, clears it after reset, carries out count, read and
// read-and-clear commands through a registered read-modify-write and answers rejected requests.
// ----------------------------------------------------------------------------
`default_nettype none

module mrct_back #(
   parameter int TABLE_DEPTH = mrct_pkg::DEF_TABLE_DEPTH,
   parameter int COUNT_BITS  = mrct_pkg::DEF_COUNT_BITS,
   parameter int ADDR_BITS   = $clog2(mrct_pkg::DEF_TABLE_DEPTH)
) (
   input  wire                                clock,
   input  wire                                reset,
   // queue head
   input  wire                                head_valid,
   input  wire  mrct_pkg::cmd_type            head_cmd,
   input  wire  [ADDR_BITS-1:0]               head_addr,
   output logic                               pop,
   output logic                               clear_busy,
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [mrct_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [mrct_pkg::RSP_USER_BITS-1:0] rsp_tuser
);
   import mrct_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [ADDR_BITS-1:0]  ADDR_LAST = ADDR_BITS'(TABLE_DEPTH - 1);
   localparam int PAD_BITS = RSP_DATA_BITS - OUT_COUNT_BITS - OUT_INDEX_BITS;

   // bin store
   logic [COUNT_BITS-1:0] mem [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

   // sequencer
   back_state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]       clr_addr_ff, clr_addr_in;
   cmd_type                    cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0]       addr_ff, addr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [OUT_COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]      incr;

   // saturating increment
   assign incr = (rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + COUNT_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = addr_ff;
      wr_addr       = addr_ff;
      wr_data       = '0;
      wr_en         = 1'b0;
      pop           = 1'b0;

      case (state_ff)
         BE_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = BE_IDLE;
            end
         end

         BE_IDLE: begin
            rd_addr = head_addr;
            if (head_valid) begin
               pop      = 1'b1;
               cmd_in   = head_cmd;
               addr_in  = head_addr;
               state_in = BE_EXEC;
            end
         end

         BE_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = cmd_ff.rsp_index;
               rsp_status_in = cmd_ff.status;
               state_in      = BE_IDLE;
               case (cmd_ff.op)
                  OP_COUNT: begin
                     wr_en        = 1'b1;
                     wr_data      = incr;
                     rsp_count_in = OUT_COUNT_BITS'(incr);
                  end
                  OP_READ: begin
                     rsp_count_in = OUT_COUNT_BITS'(rdata_ff);
                  end
                  OP_CLEAR: begin
                     wr_en        = 1'b1;
                     rsp_count_in = OUT_COUNT_BITS'(rdata_ff);
                  end
                  default: begin
                     rsp_count_in = '0;
                  end
               endcase
            end
         end

         default: state_in = BE_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and response payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign clear_busy = (state_ff == BE_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, rsp_count_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ----- sv/mrct_checker.sv -----
// ----------------------------------------------------------------------------
// mrct_checker
// Port-level checks of the contingency table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrct_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_tready,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire  [mrct_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire  [mrct_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);
   import mrct_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // the clearing pass blocks requests straight after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during clearing pass");

   // rejected count requests report bin zero and count zero
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_BAD_CODE || rsp_tuser == ST_TOO_LARGE)
         |-> rsp_tdata == '0)
      else $error("rejected count carries data");

   // an out-of-range read returns a zero count
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_BAD_INDEX |-> rsp_tdata[47:12] == '0)
      else $error("out-of-range read carries a count");

endmodule

bind mixed_radix_contingency_table mrct_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
